// ----- src/mlr_pkg.sv -----
// ----------------------------------------------------------------------------
// mlr_pkg - shared constants for the midpoint line rasteriser
// Item kind codes, default coordinate width and the window height reset value.
// ----------------------------------------------------------------------------
package mlr_pkg;

    // Default screen coordinate width in bits
    localparam int COORD_BITS_DEF = 10;

    // Window height after reset
    localparam int WINDOW_HEIGHT_RESET = 512;

    // Input item kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

endpackage

// ----- src/midpoint_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer - all-octant midpoint line rasteriser
// Loads two screen points and emits one pixel of the line per item.
// ----------------------------------------------------------------------------
// A load item (kind 0) takes two screen points, orders them so that the start
// has the larger screen y, and returns the first pixel: the start point with y
// flipped against the configured window height. Each advance item (kind 1)
// returns the next pixel, with o_last high on the end pixel, after which the
// line is closed. An advance with no open line still returns one result, with
// o_valid_res low and the other fields zero. Every item gives exactly one
// result transfer. The block takes one item per cycle while the result
// channel is not stalled; each item passes the input register, then the
// result register. The input register holds the ordered points, their
// absolute x difference and y rise, and the result register follows the
// octant reduction and pixel step. The longest path is in the second stage
// on a load: the rise/run compare, the major/minor selection and a
// three-input add that forms the decision term after the first step. An
// advance needs only the offset add for the pixel and one add for the
// decision term. Write window_height through the configuration port only
// while no item is in flight; the port is always ready.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // Configuration write channel: window height
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [COORD_BITS:0]         i_cfg_data,

    // Input item channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_kind,
    input  logic [COORD_BITS-1:0]       i_x_start,
    input  logic [COORD_BITS-1:0]       i_y_start,
    input  logic [COORD_BITS-1:0]       i_x_end,
    input  logic [COORD_BITS-1:0]       i_y_end,

    // Result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [COORD_BITS-1:0]       o_pixel_x,
    output logic signed [COORD_BITS+1:0] o_pixel_y,
    output logic                        o_valid_res,
    output logic                        o_last
);

    // Coordinate, count, height, pixel y and decision widths
    localparam int W  = COORD_BITS;
    localparam int CW = COORD_BITS + 1;
    localparam int HW = COORD_BITS + 1;
    localparam int PW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 4;

    localparam logic [HW-1:0] HEIGHT_RST = HW'(WINDOW_HEIGHT_RESET);

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    logic [HW-1:0] r_window_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_height <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_height <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------------
    // Flow control: stage A is the input register, stage B the result register
    // ------------------------------------------------------------------------
    logic r_a_valid;
    logic r_out_valid;
    logic advance;
    logic accept_in;
    logic b_fire;

    // The result register moves on when empty or when its transfer completes
    assign advance   = !r_out_valid || !i_stall;
    assign o_stall   = r_a_valid && !advance;
    assign accept_in = i_valid && !o_stall;
    assign b_fire    = r_a_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_a_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    assign o_valid = r_out_valid;

    // ------------------------------------------------------------------------
    // Stage A: order the points and take the absolute run
    // ------------------------------------------------------------------------
    logic         a_swap_pts;
    logic [W-1:0] a_sx, a_sy, a_ex, a_ey;
    logic         a_mirror;
    logic [W-1:0] a_adx;
    logic [W-1:0] a_dy;

    always_comb begin
        a_swap_pts = i_y_start < i_y_end;
        a_sx       = a_swap_pts ? i_x_end   : i_x_start;
        a_sy       = a_swap_pts ? i_y_end   : i_y_start;
        a_ex       = a_swap_pts ? i_x_start : i_x_end;
        a_ey       = a_swap_pts ? i_y_start : i_y_end;
        a_mirror   = a_ex < a_sx;
        a_adx      = a_mirror ? (a_sx - a_ex) : (a_ex - a_sx);
        a_dy       = a_sy - a_ey;
    end

    logic         r_a_kind;
    logic [W-1:0] r_a_sx;
    logic [W-1:0] r_a_sy;
    logic [W-1:0] r_a_adx;
    logic [W-1:0] r_a_dy;
    logic         r_a_mirror;

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_a_kind   <= i_kind;
            r_a_sx     <= a_sx;
            r_a_sy     <= a_sy;
            r_a_adx    <= a_adx;
            r_a_dy     <= a_dy;
            r_a_mirror <= a_mirror;
        end
    end

    // ------------------------------------------------------------------------
    // Line state
    // ------------------------------------------------------------------------
    logic                 r_active,       n_active;
    logic [W-1:0]         r_origin_x,     n_origin_x;
    logic [PW-1:0]        r_origin_y,     n_origin_y;
    logic [CW-1:0]        r_major_length, n_major_length;
    logic [CW-1:0]        r_major_count,  n_major_count;
    logic [CW-1:0]        r_minor_count,  n_minor_count;
    logic signed [DW-1:0] r_decision,     n_decision;
    logic signed [DW-1:0] r_inc_neg,      n_inc_neg;   // 2*(major - minor)
    logic signed [DW-1:0] r_inc_pos,      n_inc_pos;   // 2*minor
    logic                 r_mirror_x,     n_mirror_x;
    logic                 r_swap_axes,    n_swap_axes;

    // Result next values
    logic [W-1:0]  n_pixel_x;
    logic [PW-1:0] n_pixel_y;
    logic          n_valid_res;
    logic          n_last;

    // Load path
    logic                 b_swap;
    logic [W-1:0]         b_major;
    logic [W-1:0]         b_minor;
    logic signed [DW-1:0] b_maj_e;
    logic signed [DW-1:0] b_min_e;
    logic signed [DW-1:0] b_inc_neg;
    logic signed [DW-1:0] b_inc_pos;
    logic signed [DW-1:0] b_d0;
    logic signed [DW-1:0] b_d_neg;
    logic signed [DW-1:0] b_d_pos;
    logic                 b_fin_load;

    // Advance path
    logic [CW-1:0] b_offx;
    logic [CW-1:0] b_offy;
    logic          b_fin;

    always_comb begin
        // Octant reduction of the loaded line
        b_swap     = r_a_dy > r_a_adx;
        b_major    = b_swap ? r_a_dy  : r_a_adx;
        b_minor    = b_swap ? r_a_adx : r_a_dy;
        b_maj_e    = $signed({{(DW-W){1'b0}}, b_major});
        b_min_e    = $signed({{(DW-W){1'b0}}, b_minor});
        b_inc_neg  = (b_maj_e - b_min_e) <<< 1;
        b_inc_pos  = b_min_e <<< 1;
        b_d0       = b_maj_e - b_inc_pos;
        // Decision term after the first step, both outcomes side by side
        b_d_neg    = b_maj_e + b_inc_neg - b_inc_pos;
        b_d_pos    = b_maj_e - (b_min_e <<< 2);
        b_fin_load = (b_major == '0);

        // Pixel of the open line
        b_offx = r_swap_axes ? r_minor_count : r_major_count;
        b_offy = r_swap_axes ? r_major_count : r_minor_count;
        b_fin  = r_major_count >= r_major_length;

        // Hold by default
        n_active       = r_active;
        n_origin_x     = r_origin_x;
        n_origin_y     = r_origin_y;
        n_major_length = r_major_length;
        n_major_count  = r_major_count;
        n_minor_count  = r_minor_count;
        n_decision     = r_decision;
        n_inc_neg      = r_inc_neg;
        n_inc_pos      = r_inc_pos;
        n_mirror_x     = r_mirror_x;
        n_swap_axes    = r_swap_axes;

        n_pixel_x   = '0;
        n_pixel_y   = '0;
        n_valid_res = 1'b0;
        n_last      = 1'b0;

        case (r_a_kind)
            KIND_LOAD: begin
                // Drop any open line and emit the start point
                n_origin_x     = r_a_sx;
                n_origin_y     = {1'b0, r_window_height} - {2'b00, r_a_sy};
                n_major_length = {1'b0, b_major};
                n_inc_neg      = b_inc_neg;
                n_inc_pos      = b_inc_pos;
                n_mirror_x     = r_a_mirror;
                n_swap_axes    = b_swap;
                n_active       = !b_fin_load;
                n_major_count  = b_fin_load ? '0 : CW'(1);
                n_minor_count  = (!b_fin_load && b_d0[DW-1]) ? CW'(1) : '0;
                n_decision     = b_d0[DW-1] ? b_d_neg : b_d_pos;

                n_pixel_x   = r_a_sx;
                n_pixel_y   = {1'b0, r_window_height} - {2'b00, r_a_sy};
                n_valid_res = 1'b1;
                n_last      = b_fin_load;
            end
            KIND_ADVANCE: begin
                if (r_active) begin
                    n_pixel_x   = r_mirror_x ? (r_origin_x - b_offx[W-1:0])
                                             : (r_origin_x + b_offx[W-1:0]);
                    n_pixel_y   = r_origin_y + {1'b0, b_offy};
                    n_valid_res = 1'b1;
                    n_last      = b_fin;
                    if (b_fin) begin
                        n_active = 1'b0;
                    end else begin
                        // Step the major axis, and the minor one on a negative term
                        n_major_count = r_major_count + CW'(1);
                        if (r_decision[DW-1]) begin
                            n_decision    = r_decision + r_inc_neg;
                            n_minor_count = r_minor_count + CW'(1);
                        end else begin
                            n_decision    = r_decision - r_inc_pos;
                        end
                    end
                end
            end
            default: begin
                n_active = r_active;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_major_length <= '0;
            r_major_count  <= '0;
            r_minor_count  <= '0;
            r_decision     <= '0;
            r_inc_neg      <= '0;
            r_inc_pos      <= '0;
            r_mirror_x     <= 1'b0;
            r_swap_axes    <= 1'b0;
        end else if (b_fire) begin
            r_active       <= n_active;
            r_origin_x     <= n_origin_x;
            r_origin_y     <= n_origin_y;
            r_major_length <= n_major_length;
            r_major_count  <= n_major_count;
            r_minor_count  <= n_minor_count;
            r_decision     <= n_decision;
            r_inc_neg      <= n_inc_neg;
            r_inc_pos      <= n_inc_pos;
            r_mirror_x     <= n_mirror_x;
            r_swap_axes    <= n_swap_axes;
        end
    end

    // ------------------------------------------------------------------------
    // Result register: hold while the transfer is stalled
    // ------------------------------------------------------------------------
    logic [W-1:0]  r_pixel_x;
    logic [PW-1:0] r_pixel_y;
    logic          r_valid_res;
    logic          r_last;

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_pixel_x   <= n_pixel_x;
            r_pixel_y   <= n_pixel_y;
            r_valid_res <= n_valid_res;
            r_last      <= n_last;
        end
    end

    assign o_pixel_x   = r_pixel_x;
    assign o_pixel_y   = $signed(r_pixel_y);
    assign o_valid_res = r_valid_res;
    assign o_last      = r_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_major_count <= r_major_length))
        else $error("major count beyond line length");

    a_minor_below_major: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_minor_count <= r_major_count))
        else $error("minor count ahead of major count");

    a_last_closes_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_fire && n_last) |=> !r_active)
        else $error("line still open after its last pixel");

    a_empty_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_valid_res) |->
            (r_pixel_x == '0 && r_pixel_y == '0 && !r_last))
        else $error("empty result carries pixel data");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && r_out_valid && i_stall))
        else $error("input stalled with room in the pipeline");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the midpoint line rasteriser
// Drives load and advance items against a pixel predictor and checks every
// result transfer field by field, across several window heights and idling
// patterns, including a long receiver hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
import mlr_pkg::*;

class raster_scoreboard;

    typedef struct {
        logic [9:0]  x;
        logic [11:0] y;
        logic        vis;
        logic        fin;
    } t_pixel;

    t_pixel      pending_pixels[$];
    int          mismatches;
    logic [10:0] height;
    bit          active;
    bit          flip;
    bit          steep;
    int          org_x;
    int          org_y;
    int          major_len;
    int          minor_len;
    int          major_pos;
    int          minor_pos;
    int          err_term;

    function new();
        height     = 11'(WINDOW_HEIGHT_RESET);
        mismatches = 0;
        active     = 1'b0;
        flip       = 1'b0;
        steep      = 1'b0;
        org_x      = 0;
        org_y      = 0;
        major_len  = 0;
        minor_len  = 0;
        major_pos  = 0;
        minor_pos  = 0;
        err_term   = 0;
    endfunction

    function void set_height(logic [10:0] h);
        height = h;
    endfunction

    function int pending();
        return pending_pixels.size();
    endfunction

    // Emit the pixel at the current position; unless it is the end pixel, step along the major axis
    function t_pixel trace_pixel();
        t_pixel p;
        int     off_x;
        int     off_y;
        int     px;
        int     py;
        bit     done;
        done = (major_pos >= major_len);
        if (steep) begin
            off_x = minor_pos;
            off_y = major_pos;
        end else begin
            off_x = major_pos;
            off_y = minor_pos;
        end
        px    = flip ? org_x - off_x : org_x + off_x;
        py    = org_y + off_y;
        p.x   = 10'(px);
        p.y   = 12'(py);
        p.vis = 1'b1;
        p.fin = done;
        if (done) begin
            active = 1'b0;
        end else begin
            if (err_term < 0) begin
                err_term += 2 * (major_len - minor_len);
                minor_pos++;
            end else begin
                err_term -= 2 * minor_len;
            end
            major_pos++;
        end
        return p;
    endfunction

    function void note_item(logic kind, logic [9:0] sx, sy, ex, ey);
        int ax;
        int ay;
        int bx;
        int by;
        int t;
        int run;
        int rise;
        if (kind == KIND_LOAD) begin
            ax = sx;
            ay = sy;
            bx = ex;
            by = ey;
            if (ay < by) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            org_x = ax;
            org_y = int'(height) - ay;
            run   = bx - ax;
            rise  = ay - by;
            flip  = (run < 0);
            if (run < 0)
                run = -run;
            steep = (rise > run);
            if (steep) begin
                t = run; run = rise; rise = t;
            end
            major_len = run;
            minor_len = rise;
            major_pos = 0;
            minor_pos = 0;
            err_term  = run - 2 * rise;
            active    = 1'b1;
            pending_pixels.push_back(trace_pixel());
        end else if (!active) begin
            pending_pixels.push_back('{10'd0, 12'd0, 1'b0, 1'b0});
        end else begin
            pending_pixels.push_back(trace_pixel());
        end
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    task check_pixel(logic [9:0] x, logic [11:0] y, logic vis, logic fin);
        t_pixel want;
        if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected result x=%0d y=%0d", x, $signed(y)));
            return;
        end
        want = pending_pixels.pop_front();
        if (x !== want.x)
            report_mismatch($sformatf("pixel_x %0d, want %0d", x, want.x));
        if (y !== want.y)
            report_mismatch($sformatf("pixel_y %0d, want %0d", $signed(y), $signed(want.y)));
        if (vis !== want.vis)
            report_mismatch($sformatf("valid_res %b, want %b", vis, want.vis));
        if (fin !== want.fin)
            report_mismatch($sformatf("last %b, want %b", fin, want.fin));
    endtask

endclass

module testbench;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 8;     // pipeline is two deep; allow a margin
    localparam int HOLDOFF_CYCLES = 300;
    localparam int PHASE_ITEMS    = 100;
    localparam int NUM_PHASES     = 6;
    localparam int LIMIT_CYCLES   = 400000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data  = '0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic        i_kind      = KIND_LOAD;
    logic [9:0]  i_x_start   = '0;
    logic [9:0]  i_y_start   = '0;
    logic [9:0]  i_x_end     = '0;
    logic [9:0]  i_y_end     = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [9:0]  o_pixel_x;
    logic signed [11:0] o_pixel_y;
    logic        o_valid_res;
    logic        o_last;

    raster_scoreboard pixels = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int items_sent   = 0;
    bit holdoff_req  = 1'b0;
    bit holdoff_on   = 1'b0;

    midpoint_line_rasterizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_valid_res (o_valid_res),
        .o_last      (o_last)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 0;
    end

    // Result side: check each transfer against the oldest predicted pixel,
    // then pick the stall for the next cycle. Keep the stall high through a
    // hold-off so the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            pixels.check_pixel(o_pixel_x, o_pixel_y, o_valid_res, o_last);
        i_stall <= holdoff_on || ($urandom_range(99) < rx_stall_pct);
    end

    // Hold-off: once requested, hold the receiver off for a fixed count of cycles
    initial begin
        wait (holdoff_req);
        @(posedge i_clk);
        holdoff_on <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        holdoff_on <= 1'b0;
    end

    // Offer one item, idling first at the current rate, and hold the payload
    // until the transfer completes; note it with the predictor at that edge.
    task automatic send_item(input logic kind, input logic [9:0] sx, sy, ex, ey);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_x_start <= sx;
        i_y_start <= sy;
        i_x_end   <= ex;
        i_y_end   <= ey;
        do
            @(posedge i_clk);
        while (o_stall);
        pixels.note_item(kind, sx, sy, ex, ey);
        items_sent++;
    endtask

    // Load a line and follow it with a number of advances; coordinates on an
    // advance are ignored by the block, so fill them with noise.
    task automatic draw_line(input logic [9:0] sx, sy, ex, ey, input int steps);
        send_item(KIND_LOAD, sx, sy, ex, ey);
        repeat (steps)
            send_item(KIND_ADVANCE, 10'($urandom), 10'($urandom), 10'($urandom),
                      10'($urandom));
    endtask

    // Drop valid and wait for every predicted pixel to come back
    task automatic drain();
        i_valid <= 1'b0;
        while (pixels.pending() != 0)
            @(posedge i_clk);
    endtask

    // Write the window height while the block is idle
    task automatic write_height(input logic [10:0] h);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= h;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pixels.set_height(h);
    endtask

    // Move a coordinate by delta, reflecting the step if it would leave the screen
    function automatic logic [9:0] offset_coord(logic [9:0] base, int delta);
        int v;
        v = int'(base) + delta;
        if (v > 1023 || v < 0)
            v = int'(base) - delta;
        return 10'(v);
    endfunction

    // One random sequence: mostly short lines traced to the end (and a little
    // past it), some cut short and replaced by the next load, some stray advances.
    task automatic random_line();
        logic [9:0] sx;
        logic [9:0] sy;
        logic [9:0] ex;
        logic [9:0] ey;
        int         pick;
        int         reach;
        int         dx;
        int         dy;
        int         major;
        int         steps;
        pick = $urandom_range(99);
        sx   = 10'($urandom_range(1023));
        sy   = 10'($urandom_range(1023));
        if (pick < 6) begin
            send_item(KIND_ADVANCE, sx, sy, 10'($urandom), 10'($urandom));
            return;
        end
        if (pick < 16) begin
            draw_line(sx, sy, 10'($urandom), 10'($urandom), $urandom_range(8));
            return;
        end
        reach = (pick < 85) ? 12 : 60;
        dx    = $urandom_range(reach);
        dy    = $urandom_range(reach);
        if ($urandom_range(1))
            dx = -dx;
        if ($urandom_range(1))
            dy = -dy;
        ex    = offset_coord(sx, dx);
        ey    = offset_coord(sy, dy);
        dx    = int'(ex) - int'(sx);
        dy    = int'(ey) - int'(sy);
        dx    = (dx < 0) ? -dx : dx;
        dy    = (dy < 0) ? -dy : dy;
        major = (dx > dy) ? dx : dy;
        if ($urandom_range(9) == 0)
            steps = $urandom_range(major);
        else
            steps = major + $urandom_range(2);
        draw_line(sx, sy, ex, ey, steps);
    endtask

    initial begin
        int ph;
        int start_count;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: advance with no line open, then a single-point line and an
        // advance after its end pixel.
        send_item(KIND_ADVANCE, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        draw_line(10'd7, 10'd9, 10'd7, 10'd9, 1);
        // Field extremes; each load drops the line before it
        draw_line(10'd0, 10'd0, 10'd1023, 10'd1023, 2);
        draw_line(10'd1023, 10'd1023, 10'd0, 10'd0, 1);
        draw_line(10'd0, 10'd1023, 10'd1023, 10'd0, 0);
        draw_line(10'd1023, 10'd0, 10'd0, 10'd1023, 0);
        // Shallow line with the points given in reverse y order
        draw_line(10'd20, 10'd20, 10'd24, 10'd22, 4);
        // Steep line, end to the left of the start
        draw_line(10'd20, 10'd20, 10'd17, 10'd27, 7);
        // Shallow line heading left
        draw_line(10'd30, 10'd40, 10'd28, 10'd39, 2);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: write_height(11'd1);
                2: write_height(11'd1024);
                3: write_height(11'd0);
                4: write_height(11'd2047);
                5: write_height(11'($urandom_range(1, 1024)));
                default: ;
            endcase
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
                default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
            endcase
            // Back the pipeline up while the sender keeps offering
            if (ph == 2)
                holdoff_req = 1'b1;
            start_count = items_sent;
            // One full-length line, traced to its end pixel and one past it
            if (ph == 4)
                draw_line(10'd0, 10'($urandom), 10'd1023, 10'($urandom), 1024);
            while (items_sent - start_count < PHASE_ITEMS)
                random_line();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pixels.mismatches == 0)
            $display("** midpoint_line_rasterizer: PASSED **");
        else
            $display("** midpoint_line_rasterizer: FAILED **");
        $finish;
    end

    // Watchdog: end the run if it hangs
    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("** midpoint_line_rasterizer: FAILED **");
        $finish;
    end

endmodule
